// File: rtl/hmp_pkg.sv
// hmp_pkg: constants, sequencer states and byte helpers for the hash message padder
// no dependencies; imported by hash_message_padder and hmp_checker

package hmp_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int WORD_BYTES  = 8;
  localparam int WORD_W      = 8 * WORD_BYTES;
  localparam int COUNT_W     = 61;
  localparam int CNT_W       = 4;
  localparam int WORDS_PER_BLOCK = BLOCK_BYTES / WORD_BYTES;
  localparam int WIDX_W      = $clog2(WORDS_PER_BLOCK);

  // word slot that carries the length field
  localparam logic [WIDX_W-1:0] LEN_IDX = WIDX_W'(WORDS_PER_BLOCK - 1);
  localparam logic [7:0]        MARKER  = 8'h80;
  localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(WORD_BYTES);

  typedef enum logic [1:0] {
    ST_PASS,
    ST_MARK,
    ST_ZERO,
    ST_LEN
  } pad_state_t;

  // keep the first cnt bytes, put the marker right after them
  function automatic logic [WORD_W-1:0] mask_and_mark(input logic [WORD_W-1:0] data,
                                                      input logic [CNT_W-1:0]  cnt);
    logic [WORD_W-1:0] res;
    res = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      if (CNT_W'(i) < cnt) begin
        res[8*i +: 8] = data[8*i +: 8];
      end else if (CNT_W'(i) == cnt) begin
        res[8*i +: 8] = MARKER;
      end
    end
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] byte_swap(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] res;
    for (int i = 0; i < WORD_BYTES; i++) begin
      res[8*i +: 8] = v[8*(WORD_BYTES-1-i) +: 8];
    end
    return res;
  endfunction

endpackage

// File: rtl/hash_message_padder.sv
// hash_message_padder: md5 / sha-256 message padding on a stream of 64-bit words
// depends on hmp_pkg (constants, state type, mask and byte-swap helpers)

// Usage
//   Input channel (in_valid / in_ready): one message word per handshake, byte 0
//   in bits 7:0; byte_count is honored only on the word flagged last.
//   Output channel (out_valid / out_ready): padded words with block_end on each
//   word that closes a 64-byte block and message_end on the length word.
//   Config: cfg_write_en writes cfg_write_data into the length byte-order bit
//   (0 md5 little-endian length, 1 sha big-endian length); write only while idle.
// Timing
//   Every word goes through one output register.
//   Words that are not last stream at one per cycle while the receiver is ready.
//   After a last word the padding sequencer emits one word per cycle while the receiver
//   is ready (marker word if the last was full, zero words, length word); in_ready stays low.
// Reset clears the running byte count, the block word position, the output
//   valid and the byte-order bit (md5). A stalled receiver holds the output
//   register, which stops the input channel and the padding sequencer.

module hash_message_padder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic                       cfg_write_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [hmp_pkg::WORD_W-1:0] data_word,
  input  logic [hmp_pkg::CNT_W-1:0]  byte_count,
  input  logic                       last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [hmp_pkg::WORD_W-1:0] out_word,
  output logic                       block_end,
  output logic                       message_end
);
  import hmp_pkg::*;

  pad_state_t           state, state_next;
  logic [COUNT_W-1:0]   message_bytes, message_bytes_next;
  logic [WIDX_W-1:0]    widx, widx_next;
  logic                 length_big_endian;
  logic                 load;
  logic                 emit;
  logic [WORD_W-1:0]    word_next;
  logic                 mend_next;
  logic [CNT_W-1:0]     cnt_sat;
  logic [WIDX_W-1:0]    widx_inc;
  logic [WORD_W-1:0]    bit_len;

  // output register can take a word
  assign load     = !out_valid || out_ready;
  assign in_ready = (state == ST_PASS) && load;
  assign widx_inc = widx + WIDX_W'(1);
  assign cnt_sat  = (byte_count > FULL_CNT) ? FULL_CNT : byte_count;
  assign bit_len  = {message_bytes, 3'b000};

  // padding sequencer
  always_comb begin
    state_next         = state;
    message_bytes_next = message_bytes;
    widx_next          = widx;
    emit               = 1'b0;
    word_next          = '0;
    mend_next          = 1'b0;
    unique case (state)
      ST_PASS: begin
        if (in_valid && in_ready) begin
          emit      = 1'b1;
          widx_next = widx_inc;
          if (!last) begin
            word_next          = data_word;
            message_bytes_next = message_bytes + COUNT_W'(WORD_BYTES);
          end else begin
            message_bytes_next = message_bytes + COUNT_W'(cnt_sat);
            if (cnt_sat == FULL_CNT) begin
              word_next  = data_word;
              state_next = ST_MARK;
            end else begin
              word_next  = mask_and_mark(data_word, cnt_sat);
              state_next = (widx_inc == LEN_IDX) ? ST_LEN : ST_ZERO;
            end
          end
        end
      end
      ST_MARK: begin
        if (load) begin
          emit       = 1'b1;
          word_next  = WORD_W'(MARKER);
          widx_next  = widx_inc;
          state_next = (widx_inc == LEN_IDX) ? ST_LEN : ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (load) begin
          emit      = 1'b1;
          widx_next = widx_inc;
          if (widx_inc == LEN_IDX) begin
            state_next = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        if (load) begin
          emit               = 1'b1;
          word_next          = length_big_endian ? byte_swap(bit_len) : bit_len;
          mend_next          = 1'b1;
          widx_next          = '0;
          message_bytes_next = '0;
          state_next         = ST_PASS;
        end
      end
      default: state_next = ST_PASS;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_PASS;
      message_bytes     <= '0;
      widx              <= '0;
      out_valid         <= 1'b0;
      length_big_endian <= 1'b0;
    end else begin
      state         <= state_next;
      message_bytes <= message_bytes_next;
      widx          <= widx_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write_en) begin
        length_big_endian <= cfg_write_data;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_word    <= word_next;
      block_end   <= (widx == LEN_IDX);
      message_end <= mend_next;
    end
  end

endmodule

// File: rtl/hmp_checker.sv
// hmp_checker: port-level assertions for hash_message_padder, with its bind
// depends on hmp_pkg for the word width

module hmp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [hmp_pkg::WORD_W-1:0] out_word,
  input logic                       block_end,
  input logic                       message_end
);
  import hmp_pkg::*;

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(message_end))
    else $error("output word changed while stalled");

  // the length word always closes a block
  a_mend_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_end |-> block_end)
    else $error("message end without block end");

  // no input taken while the output register is stalled
  a_stall_no_in: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input ready during output stall");

  // an accepted word shows up on the output next cycle
  a_accept_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word not presented");

endmodule

bind hash_message_padder hmp_checker u_hmp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_word    (out_word),
  .block_end   (block_end),
  .message_end (message_end)
);
